// ===== hw/rtl/mcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcg_pkg
// shared constants, command and message codes for the midi clock generator
// ----------------------------------------------------------------------------
`default_nettype none

package mcg_pkg;

  localparam int PPQN       = 192;
  localparam int SIXTEENTH  = PPQN / 4;
  localparam int PULSE_DIV  = PPQN / 24;
  localparam int MAX_PULSES = 64;

  localparam int TICK_W  = 32;
  localparam int STATE_W = TICK_W + 1;
  localparam int MOD_W   = 11;
  localparam int MODE_W  = 2;
  localparam int FUNC_W  = 3;
  localparam int KIND_W  = 3;
  localparam int SPP_W   = 14;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 11;

  // widest divisor is SIXTEENTH times the largest modulus
  localparam int DIV_W  = $clog2(SIXTEENTH * ((1 << MOD_W) - 1) + 1);
  localparam int STEP_W = $clog2(TICK_W);
  localparam int CNT_W  = $clog2(MAX_PULSES + 1);

  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOD = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MODULUS = 2'd1;

  localparam logic [FUNC_W-1:0] FN_INIT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CONT  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_START = 3'd2;
  localparam logic [FUNC_W-1:0] FN_STOP  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLOCK = 3'd4;

  localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SPP   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PULSE = 3'd5;

  localparam logic [SPP_W-1:0] SPP_MAX = {SPP_W{1'b1}};

endpackage : mcg_pkg

`default_nettype wire

// ===== hw/rtl/midi_clock_generator.sv =====
// ----------------------------------------------------------------------------
// midi_clock_generator
// turns sequencer tick positions into midi real-time message beats
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one command beat (func, tick), taken when in_valid and !in_stall
//   out_* : result beats (msg_kind, song_position, pulse_overflow, last);
//           last marks the final beat caused by a command
//   cfg_* : register writes (clock_mode, clock_modulus), cfg_ready always high
// sequence:
//   init and continue run a shared restoring divider, one quotient bit per
//   cycle over the 32 tick bits, then an alignment step, then the result
//   beats (continue, and init from a nonzero tick in position mode, give
//   song position then continue; other inits give start)
//   clock runs a compare/count step, then one beat per due pulse (max 64)
//   start and stop go straight to a single result beat; while mode is off no beat is given
//   in_stall is high from the accepting edge until the sequencer is idle again
// reset:
//   clock off, modulus 64, last clocked tick -1, no result pending
// back-pressure:
//   the output register holds its beat while out_stall is high; the
//   sequencer waits on it, and a new command can still be taken while the
//   final beat of the previous one waits to be read
// ----------------------------------------------------------------------------
`default_nettype none

module midi_clock_generator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // command channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mcg_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [mcg_pkg::TICK_W-1:0]  in_tick,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mcg_pkg::KIND_W-1:0]       out_msg_kind,
  output logic [mcg_pkg::SPP_W-1:0]        out_song_position,
  output logic                             out_pulse_overflow,
  output logic                             out_last,
  // configuration writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mcg_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [mcg_pkg::CDAT_W-1:0]  cfg_data
);
  import mcg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ALIGN,
    ST_PULSE,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;

  // configuration registers
  logic [MODE_W-1:0]   mode_r;
  logic [MOD_W-1:0]    modulus_r;

  // sequencer state
  logic [STATE_W-1:0]  last_tick_r, last_tick_nxt;   // two's complement
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic                align_r, align_nxt;           // start alignment vs song position

  // shared divider
  logic [TICK_W-1:0]   quo_r, quo_nxt;               // dividend shifts out, quotient in
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    div_r, div_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  // emission
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [SPP_W-1:0]    spp_r, spp_nxt;
  logic                ovf_r, ovf_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [SPP_W-1:0]    out_spp_r, out_spp_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic                out_last_r, out_last_nxt;

  // decode helpers
  logic                pos_mode, mod_mode, active;
  logic                in_take;
  logic [MOD_W-1:0]    mod_eff;
  logic [DIV_W-1:0]    align_unit;

  // divider datapath
  logic [DIV_W:0]      rem_sh;
  logic                rem_ge;

  // alignment datapath
  logic [STATE_W:0]    aligned;                      // 34 bits, signed

  // pulse count datapath
  logic [STATE_W-1:0]  lo_tick;
  logic [STATE_W:0]    lo_ceil;
  logic [STATE_W:0]    due;
  logic                clock_due;

  logic                slot_free;

  assign pos_mode = (mode_r == MODE_POS);
  assign mod_mode = (mode_r == MODE_MOD);
  assign active   = pos_mode | mod_mode;                // mode 3 acts as off

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // alignment unit for modulo starts; zero modulus counts as one
  assign mod_eff    = (modulus_r == '0) ? MOD_W'(1) : modulus_r;
  assign align_unit = DIV_W'(mod_eff) * DIV_W'(SIXTEENTH);

  // one restoring division step
  assign rem_sh = {rem_r, quo_r[TICK_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_r});

  // tick rounded up to the divisor, minus one
  assign aligned = {2'b00, tick_r} - {{(STATE_W+1-DIV_W){1'b0}}, rem_r}
                 + ((rem_r != '0) ? {{(STATE_W+1-DIV_W){1'b0}}, div_r} : '0)
                 - (STATE_W+1)'(1);

  // pulses due between last_tick+1 and tick inclusive
  assign lo_tick   = last_tick_r + STATE_W'(1);
  assign lo_ceil   = ({1'b0, lo_tick} + (STATE_W+1)'(PULSE_DIV - 1)) / PULSE_DIV;
  assign due       = (STATE_W+1)'(tick_r / PULSE_DIV) + (STATE_W+1)'(1) - lo_ceil;
  assign clock_due = ($signed(last_tick_r) < $signed({1'b0, tick_r}));

  assign slot_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt     = state_r;
    last_tick_nxt = last_tick_r;
    tick_nxt      = tick_r;
    align_nxt     = align_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    spp_nxt       = spp_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_spp_nxt   = out_spp_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          tick_nxt = in_tick;
          quo_nxt  = in_tick;
          rem_nxt  = '0;
          step_nxt = '0;
          spp_nxt  = '0;
          ovf_nxt  = 1'b0;
          case (in_func)
            FN_INIT: begin
              if (pos_mode && in_tick != '0) begin
                div_nxt   = DIV_W'(SIXTEENTH);
                align_nxt = 1'b0;
                state_nxt = ST_DIV;
              end else if (mod_mode || in_tick == '0) begin
                div_nxt   = align_unit;
                align_nxt = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            FN_CONT: begin
              div_nxt   = DIV_W'(SIXTEENTH);
              align_nxt = 1'b0;
              state_nxt = ST_DIV;
            end
            FN_START, FN_STOP: begin
              last_tick_nxt = '1;
              if (active) begin
                kind_nxt  = (in_func == FN_START) ? KIND_START : KIND_STOP;
                cnt_nxt   = CNT_W'(1);
                state_nxt = ST_EMIT;
              end
            end
            FN_CLOCK: begin
              if (active) begin
                state_nxt = ST_PULSE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_DIV: begin
        rem_nxt  = rem_ge ? DIV_W'(rem_sh - {1'b0, div_r}) : rem_sh[DIV_W-1:0];
        quo_nxt  = {quo_r[TICK_W-2:0], rem_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(TICK_W - 1)) begin
          state_nxt = ST_ALIGN;
        end
      end

      ST_ALIGN: begin
        // clamp past the top of the tick range
        if (aligned[STATE_W] == 1'b0 && aligned[STATE_W-1] == 1'b1) begin
          last_tick_nxt = {1'b0, {TICK_W{1'b1}}};
        end else begin
          last_tick_nxt = aligned[STATE_W-1:0];
        end
        if (!active) begin
          state_nxt = ST_IDLE;
        end else if (align_r) begin
          kind_nxt  = KIND_START;
          cnt_nxt   = CNT_W'(1);
          state_nxt = ST_EMIT;
        end else begin
          kind_nxt  = KIND_SPP;
          spp_nxt   = (quo_r > TICK_W'(SPP_MAX)) ? SPP_MAX : quo_r[SPP_W-1:0];
          cnt_nxt   = CNT_W'(2);
          state_nxt = ST_EMIT;
        end
      end

      ST_PULSE: begin
        state_nxt = ST_IDLE;
        if (clock_due) begin
          last_tick_nxt = {1'b0, tick_r};
          kind_nxt      = KIND_PULSE;
          if (due > (STATE_W+1)'(MAX_PULSES)) begin
            cnt_nxt   = CNT_W'(MAX_PULSES);
            ovf_nxt   = 1'b1;
            state_nxt = ST_EMIT;
          end else if (due != '0) begin
            cnt_nxt   = due[CNT_W-1:0];
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_spp_nxt   = (kind_r == KIND_SPP) ? spp_r : '0;
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = (cnt_r == CNT_W'(1));
          cnt_nxt       = cnt_r - CNT_W'(1);
          // song position is followed by continue
          if (kind_r == KIND_SPP) begin
            kind_nxt = KIND_CONT;
          end
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_OFF;
      modulus_r   <= MOD_W'(64);
      last_tick_r <= '1;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
      kind_r      <= KIND_NONE;
      out_kind_r  <= KIND_NONE;
    end else begin
      state_r     <= state_nxt;
      last_tick_r <= last_tick_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      kind_r      <= kind_nxt;
      out_kind_r  <= out_kind_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:    mode_r    <= cfg_data[MODE_W-1:0];
          CFG_MODULUS: modulus_r <= cfg_data[MOD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tick_r     <= tick_nxt;
    align_r    <= align_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    spp_r      <= spp_nxt;
    ovf_r      <= ovf_nxt;
    out_spp_r  <= out_spp_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_msg_kind       = out_kind_r;
  assign out_song_position  = out_spp_r;
  assign out_pulse_overflow = out_ovf_r;
  assign out_last           = out_last_r;

endmodule : midi_clock_generator

`default_nettype wire
